@@ hw/rtl/dmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dmf_pkg: shared types and constants of the duplicate message filter
// Table geometry, field widths, command codes and the command passed from
// the front to the table engine.
// ----------------------------------------------------------------------------
package dmf_pkg;

   localparam int CAPACITY  = 64;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int MSG_W     = 32;
   localparam int SENDER_W  = 16;
   localparam int AGE_W     = 16;
   localparam int ELAPSED_W = 12;
   localparam int EXPIRE_W  = 16;
   localparam int USE_W     = 7;

   localparam logic [EXPIRE_W-1:0] EXPIRE_RESET = EXPIRE_W'(5000);
   localparam logic [IDX_W:0]      SCAN_END     = (IDX_W + 1)'(CAPACITY);

   // command queue between front and engine
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] CMD_PASS  = 2'd0;
   localparam logic [1:0] CMD_CHECK = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   typedef struct packed {
      logic [1:0]           code;
      logic [MSG_W-1:0]     msg_id;
      logic [SENDER_W-1:0]  sender_id;
      logic [ELAPSED_W-1:0] elapsed;
   } cmd_type;

   typedef struct packed {
      logic [MSG_W-1:0]    msg_id;
      logic [SENDER_W-1:0] sender_id;
      logic [AGE_W-1:0]    age;
   } entry_type;

endpackage

@@ hw/rtl/dmf_front.sv @@
// ----------------------------------------------------------------------------
// dmf_front: request intake and command queue
// Accepts request transactions, sorts them into tick, tracked check and
// untracked check commands and buffers them for the table engine.
// ----------------------------------------------------------------------------
module dmf_front
   import dmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic                 req_is_important,
   input  logic [MSG_W-1:0]     req_msg_id,
   input  logic [SENDER_W-1:0]  req_sender_id,
   input  logic [ELAPSED_W-1:0] req_elapsed,
   output logic                 q_valid,
   output cmd_type              q_cmd,
   input  logic                 q_pop
);

   cmd_type            q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  q_cnt_ff, q_cnt_in;
   cmd_type            push_cmd;
   logic               push;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

   assign req_ready = (q_cnt_ff != CNT_FULL);
   assign push      = req_valid && req_ready;
   assign q_valid   = (q_cnt_ff != '0);
   assign q_cmd     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      push_cmd.msg_id    = req_msg_id;
      push_cmd.sender_id = req_sender_id;
      push_cmd.elapsed   = req_elapsed;
      if (req_operation) begin
         push_cmd.code = CMD_TICK;
      end else if (req_is_important) begin
         push_cmd.code = CMD_CHECK;
      end else begin
         push_cmd.code = CMD_PASS;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/dmf_engine.sv @@
// ----------------------------------------------------------------------------
// dmf_engine: table engine
// Walks the entry memory one slot per cycle for tracked checks and ticks,
// keeps the valid bits and fill count, holds the expiry register and response.
// ----------------------------------------------------------------------------
module dmf_engine
   import dmf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [EXPIRE_W-1:0] csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_duplicate,
   output logic                rsp_dropped_full,
   output logic [USE_W-1:0]    rsp_entries_in_use
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   entry_type             mem [CAPACITY];

   logic [1:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IDX_W:0]        scan_ff, scan_in;
   logic                  pipe_vld_ff;
   logic [IDX_W-1:0]      pipe_idx_ff;
   entry_type             rd_data_ff;
   logic                  dup_ff, dup_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [EXPIRE_W-1:0]   expire_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dup_ff, rsp_drop_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;
   logic                  cur_valid;
   logic [AGE_W:0]        age_sum;
   logic [AGE_W-1:0]      age_new;
   logic                  fire;
   logic                  insert;
   logic                  dropped;
   logic [CNT_W+USE_W-1:0] count_ext;

   assign csr_ready = 1'b1;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rd_en     = (state_ff == ST_SCAN) && (scan_ff != SCAN_END);
   assign rd_addr   = scan_ff[IDX_W-1:0];
   assign cur_valid = valid_ff[pipe_idx_ff];
   assign age_sum   = {1'b0, rd_data_ff.age}
                      + {{(AGE_W + 1 - ELAPSED_W){1'b0}}, cmd_ff.elapsed};
   // ages stop at the top of their range
   assign age_new   = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
   assign fire      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign insert    = (cmd_ff.code == CMD_CHECK) && !dup_ff && free_found_ff;
   assign dropped   = (cmd_ff.code == CMD_CHECK) && !dup_ff && !free_found_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_in       = scan_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = pipe_idx_ff;
      wr_data       = rd_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in        = q_cmd;
               scan_in       = '0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = (q_cmd.code == CMD_PASS) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               scan_in = scan_ff + 1'b1;
            end
            if (pipe_vld_ff) begin
               if (cmd_ff.code == CMD_TICK) begin
                  if (cur_valid) begin
                     wr_en       = 1'b1;
                     wr_data.age = age_new;
                     if (age_new > expire_ff) begin
                        valid_in[pipe_idx_ff] = 1'b0;
                        count_in              = count_ff - 1'b1;
                     end
                  end
               end else begin
                  if (cur_valid) begin
                     if (rd_data_ff.msg_id == cmd_ff.msg_id &&
                         rd_data_ff.sender_id == cmd_ff.sender_id) begin
                        dup_in = 1'b1;
                     end
                  end else if (!free_found_ff) begin
                     // lowest free slot wins
                     free_found_in = 1'b1;
                     free_idx_in   = pipe_idx_ff;
                  end
               end
            end else if (scan_ff == SCAN_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (insert) begin
                  wr_en                 = 1'b1;
                  wr_addr               = free_idx_ff;
                  wr_data.msg_id        = cmd_ff.msg_id;
                  wr_data.sender_id     = cmd_ff.sender_id;
                  wr_data.age           = '0;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         pipe_vld_ff   <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         expire_ff     <= EXPIRE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         pipe_vld_ff   <= rd_en;
         dup_ff        <= dup_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            expire_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      free_idx_ff <= free_idx_in;
      pipe_idx_ff <= rd_addr;
      if (fire) begin
         rsp_dup_ff   <= dup_ff;
         rsp_drop_ff  <= dropped;
         rsp_count_ff <= count_in;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign count_ext          = {{USE_W{1'b0}}, rsp_count_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duplicate      = rsp_dup_ff;
   assign rsp_dropped_full   = rsp_drop_ff;
   assign rsp_entries_in_use = count_ext[USE_W-1:0];

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == $countones(valid_ff))
      else $error("fill count out of step with valid bits");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("entry write while idle");

   a_dup_excludes_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_dup_ff && rsp_drop_ff))
      else $error("duplicate and dropped flagged together");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_ff == SCAN_END && !pipe_vld_ff)
      |=> (state_ff == ST_FINISH))
      else $error("scan did not hand over to finish");

endmodule

@@ hw/rtl/duplicate_message_filter.sv @@
// ----------------------------------------------------------------------------
// duplicate_message_filter: duplicate detection table with expiry
// Remembers recently seen (message id, sender id) pairs and ages them out.
// ----------------------------------------------------------------------------
// Request channel (req_*): one transaction per message check or time tick.
//   req_operation 0 checks a message, 1 adds req_elapsed ms to every age.
// Response channel (rsp_*): exactly one transaction per request, in order,
//   with the duplicate and table-full flags and the entry count afterwards.
// Configuration channel (csr_*): writes the expiry age in ms; always ready.
//   Write it only while no request is in flight.
// Scanning: a tracked check or a tick walks the entry memory one slot per
//   cycle through its single read port; an untracked check skips the walk.
//   A two-entry command queue in front keeps req_ready high while the
//   engine works on an earlier request.
// Reset: synchronous; all entries become free, expiry returns to 5000 ms.
// Stall: when rsp_ready is low the response is held in its output register;
//   the engine waits for it and the queue fills, then req_ready drops.
// ----------------------------------------------------------------------------
module duplicate_message_filter
   import dmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic                 req_is_important,
   input  logic [MSG_W-1:0]     req_msg_id,
   input  logic [SENDER_W-1:0]  req_sender_id,
   input  logic [ELAPSED_W-1:0] req_elapsed,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_duplicate,
   output logic                 rsp_dropped_full,
   output logic [USE_W-1:0]     rsp_entries_in_use,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [EXPIRE_W-1:0]  csr_wdata
);

   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   dmf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_is_important (req_is_important),
      .req_msg_id       (req_msg_id),
      .req_sender_id    (req_sender_id),
      .req_elapsed      (req_elapsed),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   dmf_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_cmd              (q_cmd),
      .q_pop              (q_pop),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_duplicate      (rsp_duplicate),
      .rsp_dropped_full   (rsp_dropped_full),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

endmodule
